// File: design/wcs_pkg.sv
// ----------------------------------------------------------------------------
// wcs_pkg
// shared types and codes for the wash cycle sequencer
// ----------------------------------------------------------------------------
package wcs_pkg;

  // time arithmetic width, elapsed time wraps modulo 2**TIME_BITS
  localparam int TIME_BITS = 32;
  localparam int CFG_W     = 32;
  localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int CFG_IDX_W = 3;
  localparam int ATT_W     = 4;
  localparam int PHASE_W   = 3;
  localparam int OP_W      = 2;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [CFG_W-1:0]     cfg_t;

  // op codes
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_ABORT  = 2'd1;
  localparam logic [OP_W-1:0] OP_ARESET = 2'd2;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WASH  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_POST  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SAFE  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RETRY = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DEGR  = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WASH_MAX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WASH_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESID_ROT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANTI_RST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_PS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATT   = 3'd6;

  localparam logic [ATT_W-1:0] ATT_MAX       = 4'd15;
  localparam logic [ATT_W-1:0] MAX_ATT_RESET = 4'd3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [31:0]     now_ms;
    logic            wash_request;
  } wcs_in_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_code;
    logic               drum_on;
    logic               rinse_on;
    logic               wash_lamp;
    logic               alarm_lamp;
    logic               request_pending;
    logic               blocking_alarm;
  } wcs_out_t;

endpackage

// File: design/wash_cycle_sequencer_core.sv
// ----------------------------------------------------------------------------
// wash_cycle_sequencer_core
// wash sequencer: request delay, wash window, post rotation, safety pause,
// retry on timeout and latched degraded alarm, one result per event
// ----------------------------------------------------------------------------
//
//  channel | ports                               | transfer
//  --------+-------------------------------------+--------------------------
//  in      | in_valid  in_ready  in_data         | one event transaction
//  out     | out_valid out_ready out_data        | one result transaction
//  cfg     | cfg_valid cfg_ready cfg_index/data  | one register write
//
//  an abort, alarm reset or unused op goes from accept straight to the done state
//  a timed update first passes through the timed checks of the shared
//  elapsed-time unit, one state per check (two checks while washing); the
//  chain length is set by the single subtract/compare unit
//  the result sits in an output register, so the next event is taken while
//  it waits; a finished event stalls only if the previous result is unread
//  reset is synchronous, active low; cfg_ready is always high
//
module wash_cycle_sequencer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wcs_pkg::wcs_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wcs_pkg::wcs_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wcs_pkg::CFG_W-1:0]         cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an event
  localparam logic [2:0] S_REQ  = 3'd1;  // request delay check
  localparam logic [2:0] S_STEP = 3'd2;  // phase timeout check
  localparam logic [2:0] S_WMIN = 3'd3;  // wash minimum / release check
  localparam logic [2:0] S_DONE = 3'd4;  // hand result to output register

  // configuration registers
  wcs_pkg::cfg_t wash_max_r, wash_min_r, resid_rot_r, anti_rst_r, retry_ps_r, req_delay_r;
  logic [wcs_pkg::ATT_W-1:0] max_att_r;

  // sequencer and block state
  logic [2:0]                  state_r, state_nxt;
  logic [wcs_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  wcs_pkg::time_t              start_r, start_nxt;
  logic [wcs_pkg::ATT_W-1:0]   att_r, att_nxt;
  logic                        seen_r, seen_nxt;
  wcs_pkg::time_t              since_r, since_nxt;

  // latched event
  logic [wcs_pkg::OP_W-1:0] op_r;
  wcs_pkg::time_t           now_r;
  logic                     req_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  wcs_pkg::wcs_out_t out_data_r, out_data_nxt;

  // shared unit hookup
  wcs_pkg::time_t base_sel;
  wcs_pkg::cfg_t  thr_sel;
  logic           ge;
  logic           in_fire, out_free;

  wcs_cmp_unit u_cmp (
    .now_t  (now_r),
    .base_t (base_sel),
    .thr    (thr_sel),
    .ge     (ge)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // operand select for the shared unit
  always_comb begin
    base_sel = start_r;
    thr_sel  = wash_max_r;
    if (state_r == S_REQ) begin
      base_sel = since_r;
      thr_sel  = req_delay_r;
    end else if (state_r == S_WMIN) begin
      thr_sel = wash_min_r;
    end else begin
      case (phase_r)
        wcs_pkg::PH_POST:  thr_sel = resid_rot_r;
        wcs_pkg::PH_SAFE:  thr_sel = anti_rst_r;
        wcs_pkg::PH_RETRY: thr_sel = retry_ps_r;
        default:           thr_sel = wash_max_r;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    att_nxt       = att_r;
    seen_nxt      = seen_r;
    since_nxt     = since_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DONE;
          case (in_data.op)
            wcs_pkg::OP_UPDATE: begin
              if (phase_r == wcs_pkg::PH_IDLE) begin
                if (!in_data.wash_request) begin
                  seen_nxt = 1'b0;
                end else begin
                  // first sighting of the request starts the delay
                  if (!seen_r) begin
                    seen_nxt  = 1'b1;
                    since_nxt = wcs_pkg::time_t'(in_data.now_ms);
                  end
                  state_nxt = S_REQ;
                end
              end else begin
                state_nxt = S_STEP;
              end
            end
            wcs_pkg::OP_ABORT: begin
              if (phase_r != wcs_pkg::PH_DEGR) begin
                phase_nxt = wcs_pkg::PH_IDLE;
                att_nxt   = '0;
                seen_nxt  = 1'b0;
              end
            end
            wcs_pkg::OP_ARESET: begin
              phase_nxt = wcs_pkg::PH_IDLE;
              att_nxt   = '0;
              seen_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end

      S_REQ: begin
        state_nxt = S_DONE;
        if (ge) begin
          phase_nxt = wcs_pkg::PH_WASH;
          start_nxt = now_r;
          att_nxt   = (att_r < wcs_pkg::ATT_MAX) ? att_r + 1'b1 : att_r;
          seen_nxt  = 1'b0;
          state_nxt = S_STEP;
        end
      end

      S_STEP: begin
        state_nxt = S_DONE;
        case (phase_r)
          wcs_pkg::PH_WASH: begin
            if (ge) begin
              // timeout: retry or latch the alarm once attempts are used up
              phase_nxt = (att_r >= max_att_r) ? wcs_pkg::PH_DEGR : wcs_pkg::PH_RETRY;
              start_nxt = now_r;
              state_nxt = S_STEP;
            end else begin
              state_nxt = S_WMIN;
            end
          end
          wcs_pkg::PH_POST: begin
            if (ge) begin
              phase_nxt = wcs_pkg::PH_SAFE;
              start_nxt = now_r;
              state_nxt = S_STEP;
            end
          end
          wcs_pkg::PH_SAFE: begin
            if (ge) begin
              phase_nxt = wcs_pkg::PH_IDLE;
              att_nxt   = '0;
              seen_nxt  = 1'b0;
            end
          end
          wcs_pkg::PH_RETRY: begin
            if (ge) begin
              if (req_r) begin
                phase_nxt = wcs_pkg::PH_WASH;
                start_nxt = now_r;
                att_nxt   = (att_r < wcs_pkg::ATT_MAX) ? att_r + 1'b1 : att_r;
                seen_nxt  = 1'b0;
                state_nxt = S_STEP;
              end else begin
                phase_nxt = wcs_pkg::PH_IDLE;
                att_nxt   = '0;
                seen_nxt  = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end

      S_WMIN: begin
        state_nxt = S_DONE;
        if (ge && !req_r) begin
          phase_nxt = wcs_pkg::PH_POST;
          start_nxt = now_r;
          state_nxt = S_STEP;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.phase_code       = phase_r;
          out_data_nxt.drum_on          = (phase_r == wcs_pkg::PH_WASH) ||
                                          (phase_r == wcs_pkg::PH_POST);
          out_data_nxt.rinse_on         = (phase_r == wcs_pkg::PH_WASH);
          out_data_nxt.wash_lamp        = (phase_r == wcs_pkg::PH_WASH) ||
                                          (phase_r == wcs_pkg::PH_POST);
          out_data_nxt.alarm_lamp       = (phase_r == wcs_pkg::PH_DEGR);
          out_data_nxt.request_pending  = (op_r == wcs_pkg::OP_UPDATE) &&
                                          (phase_r == wcs_pkg::PH_IDLE) && req_r;
          out_data_nxt.blocking_alarm   = (phase_r == wcs_pkg::PH_DEGR);
          state_nxt                     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= wcs_pkg::PH_IDLE;
      start_r     <= '0;
      att_r       <= '0;
      seen_r      <= 1'b0;
      since_r     <= '0;
      out_valid_r <= 1'b0;
      wash_max_r  <= '0;
      wash_min_r  <= '0;
      resid_rot_r <= '0;
      anti_rst_r  <= '0;
      retry_ps_r  <= '0;
      req_delay_r <= '0;
      max_att_r   <= wcs_pkg::MAX_ATT_RESET;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      att_r       <= att_nxt;
      seen_r      <= seen_nxt;
      since_r     <= since_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wcs_pkg::REG_WASH_MAX:  wash_max_r  <= cfg_data;
          wcs_pkg::REG_WASH_MIN:  wash_min_r  <= cfg_data;
          wcs_pkg::REG_RESID_ROT: resid_rot_r <= cfg_data;
          wcs_pkg::REG_ANTI_RST:  anti_rst_r  <= cfg_data;
          wcs_pkg::REG_RETRY_PS:  retry_ps_r  <= cfg_data;
          wcs_pkg::REG_REQ_DELAY: req_delay_r <= cfg_data;
          wcs_pkg::REG_MAX_ATT:   max_att_r   <= cfg_data[wcs_pkg::ATT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // event and result payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_data.op;
      now_r <= wcs_pkg::time_t'(in_data.now_ms);
      req_r <= in_data.wash_request;
    end
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // an accepted event always moves the sequencer out of the idle state on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer ready right after accepting an event");

  // a result handed off in the done state shows up as valid
  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> out_valid_r)
    else $error("done state did not load the output register");

  // the degraded alarm survives any timed check
  a_degr_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP && phase_r == wcs_pkg::PH_DEGR) |=> (phase_r == wcs_pkg::PH_DEGR))
    else $error("degraded phase left during a timed update");

  // rinse only while washing
  a_rinse_only_wash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.rinse_on == (out_data_r.phase_code == wcs_pkg::PH_WASH)))
    else $error("rinse output disagrees with reported phase");

  // a new wash after the request delay always counts an attempt
  a_wash_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REQ && ge) |=> (phase_r == wcs_pkg::PH_WASH && att_r != '0))
    else $error("wash start did not count an attempt");
`endif

endmodule

// File: design/wcs_cmp_unit.sv
// ----------------------------------------------------------------------------
// wcs_cmp_unit
// shared elapsed-time unit: wrapping subtract, then unsigned compare
// ----------------------------------------------------------------------------
module wcs_cmp_unit (
  input  wcs_pkg::time_t now_t,
  input  wcs_pkg::time_t base_t,
  input  wcs_pkg::cfg_t  thr,
  output logic           ge
);

  wcs_pkg::time_t elapsed;

  // difference wraps at the time width
  assign elapsed = now_t - base_t;
  assign ge      = wcs_pkg::cmp_t'(elapsed) >= wcs_pkg::cmp_t'(thr);

endmodule
